// ===== rtl/core/b2d_pkg.sv =====
// Shared constants and types for the binary to decimal ASCII converter.
`default_nettype none

package b2d_pkg;

    localparam int unsigned VALUE_W = 64;
    localparam int unsigned DIGITS  = 20;           // decimal digits of 2^64 - 1
    localparam int unsigned BCD_W   = 4 * DIGITS;
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned BITCNT_W = $clog2(VALUE_W + 1);
    localparam int unsigned DIGCNT_W = $clog2(DIGITS + 1);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    localparam logic FUNC_UNSIGNED = 1'b0;
    localparam logic FUNC_SIGNED   = 1'b1;

    // Converted number handed from the converter to the character emitter.
    typedef struct packed {
        logic             neg;
        logic [BCD_W-1:0] bcd;
    } b2d_num_t;

endpackage

`default_nettype wire

// ===== rtl/core/b2d_dabble.sv =====
// Bit-serial shift-and-add-3 converter from a 64-bit magnitude to packed BCD.
`default_nettype none

module b2d_dabble
    import b2d_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [VALUE_W-1:0] in_value,
    input  wire logic               in_func,
    output logic                    num_valid,
    input  wire logic               num_ready,
    output b2d_num_t                num
);

    typedef enum logic [1:0] {D_IDLE, D_RUN, D_DONE} dab_state_t;

    dab_state_t          state_reg, state_next;
    logic [VALUE_W-1:0]  mag_reg, mag_next;
    logic [BCD_W-1:0]    bcd_reg, bcd_next;
    logic [BITCNT_W-1:0] cnt_reg, cnt_next;
    logic                neg_reg, neg_next;
    logic [BCD_W-1:0]    bcd_adj;
    logic                in_neg;

    assign in_neg = (in_func == FUNC_SIGNED) && in_value[VALUE_W-1];

    // Add 3 to every digit of 5 or more before the shift.
    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        mag_next   = mag_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        unique case (state_reg)
            D_IDLE: begin
                if (in_valid) begin
                    // Most negative value negates to itself, which is the right magnitude.
                    mag_next   = in_neg ? (~in_value + 1'b1) : in_value;
                    neg_next   = in_neg;
                    bcd_next   = '0;
                    cnt_next   = BITCNT_W'(VALUE_W);
                    state_next = D_RUN;
                end
            end
            D_RUN: begin
                bcd_next = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_W-1]};
                mag_next = {mag_reg[VALUE_W-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == BITCNT_W'(1)) begin
                    state_next = D_DONE;
                end
            end
            D_DONE: begin
                if (num_ready) begin
                    state_next = D_IDLE;
                end
            end
            default: state_next = D_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
        end else begin
            state_reg <= state_next;
        end
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
    end

    assign in_ready  = (state_reg == D_IDLE);
    assign num_valid = (state_reg == D_DONE);
    assign num.neg   = neg_reg;
    assign num.bcd   = bcd_reg;

endmodule

`default_nettype wire

// ===== rtl/core/b2d_emit.sv =====
// Digit-serial character emitter: sign, then BCD digits without leading zeros.
`default_nettype none

module b2d_emit
    import b2d_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              num_valid,
    output logic                   num_ready,
    input  wire b2d_num_t          num,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [CHAR_W-1:0]      m_tdata,
    output logic                   m_tlast
);

    typedef enum logic [1:0] {E_IDLE, E_SIGN, E_DIGITS} emit_state_t;

    emit_state_t         state_reg, state_next;
    logic [BCD_W-1:0]    bcd_reg, bcd_next;
    logic [DIGCNT_W-1:0] cnt_reg, cnt_next;
    logic                lead_reg, lead_next;
    logic                valid_reg, valid_next;
    logic [CHAR_W-1:0]   char_reg, char_next;
    logic                last_reg, last_next;
    logic                out_free;
    logic [3:0]          top_digit;
    logic                is_last;

    assign out_free  = !valid_reg || m_tready;
    assign top_digit = bcd_reg[BCD_W-1 -: 4];
    assign is_last   = (cnt_reg == DIGCNT_W'(1));

    always_comb begin
        state_next = state_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        lead_next  = lead_reg;
        valid_next = valid_reg && !m_tready;
        char_next  = char_reg;
        last_next  = last_reg;
        unique case (state_reg)
            E_IDLE: begin
                if (num_valid) begin
                    bcd_next   = num.bcd;
                    cnt_next   = DIGCNT_W'(DIGITS);
                    lead_next  = 1'b1;
                    state_next = num.neg ? E_SIGN : E_DIGITS;
                end
            end
            E_SIGN: begin
                if (out_free) begin
                    valid_next = 1'b1;
                    char_next  = CHAR_MINUS;
                    last_next  = 1'b0;
                    state_next = E_DIGITS;
                end
            end
            E_DIGITS: begin
                if (out_free) begin
                    // Leading zeros are dropped, but the ones digit always goes out.
                    if (!lead_reg || (top_digit != 4'd0) || is_last) begin
                        valid_next = 1'b1;
                        char_next  = CHAR_ZERO | {4'd0, top_digit};
                        last_next  = is_last;
                        lead_next  = 1'b0;
                    end
                    bcd_next = {bcd_reg[BCD_W-5:0], 4'd0};
                    cnt_next = cnt_reg - 1'b1;
                    if (is_last) begin
                        state_next = E_IDLE;
                    end
                end
            end
            default: state_next = E_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= E_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
        bcd_reg  <= bcd_next;
        cnt_reg  <= cnt_next;
        lead_reg <= lead_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign num_ready = (state_reg == E_IDLE);
    assign m_tvalid  = valid_reg;
    assign m_tdata   = char_reg;
    assign m_tlast   = last_reg;

endmodule

`default_nettype wire

// ===== rtl/core/binary_to_decimal_ascii.sv =====
// Top level of the 64-bit binary to decimal ASCII converter.
`default_nettype none

// Takes one 64-bit operand per input transfer, read as unsigned or as two's
// complement signed per s_tuser, and sends its decimal text as a stream of
// ASCII bytes, most significant first, m_tlast on the final byte. Negative
// signed operands get a leading '-'; zero gives a single '0'; the most
// negative value prints as -9223372036854775808. Conversion is bit serial:
// a load step that also negates, 64 shift-and-add-3 steps (one operand bit
// each) into a 20-digit BCD register, then a handoff of the digits to the
// emitter. The emitter then walks all 20 digit positions, one per cycle
// while its output register is free, after a sign if there is one. The two
// run in parallel, so with a free-flowing output the operand rate is set
// by the 64-step shift loop. Output stalls hold the emitter and, once it is
// full, the converter.

module binary_to_decimal_ascii
    import b2d_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [VALUE_W-1:0] s_tdata,   // [63:0] value
    input  wire logic               s_tuser,   // [0] func: 0 unsigned, 1 signed
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [CHAR_W-1:0]       m_tdata,   // [7:0] character
    output logic                    m_tlast    // last character of the number
);

    // Converter to emitter transfer.
    logic     num_valid;
    logic     num_ready;
    b2d_num_t num;

    b2d_dabble u_dabble (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_value  (s_tdata),
        .in_func   (s_tuser),
        .num_valid (num_valid),
        .num_ready (num_ready),
        .num       (num)
    );

    b2d_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .num_valid (num_valid),
        .num_ready (num_ready),
        .num       (num),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // A sign is never the end of a number.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata == CHAR_MINUS)) |-> !m_tlast)
        else $error("minus sign marked as last character");

    // Only digits and the sign ever leave the block.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata >= CHAR_ZERO && m_tdata <= (CHAR_ZERO | 8'h09))
                      || (m_tdata == CHAR_MINUS)))
        else $error("non-decimal character on output");

    // The top BCD digit handed over must be 0 or 1.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (num_valid && num_ready) |-> (num.bcd[BCD_W-1 -: 4] <= 4'd1))
        else $error("top BCD digit out of range at handoff");

endmodule

`default_nettype wire

// ===== dv/b2d_text_checker.sv =====
// Checker for the decimal converter: predicts the character run of each operand and compares.
`timescale 1ns / 1ps

module b2d_text_checker
    import b2d_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [VALUE_W-1:0] s_tdata,
    input  logic               s_tuser,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [CHAR_W-1:0]  m_tdata,
    input  logic               m_tlast,
    output int                 mismatch_count,
    output int                 chars_outstanding
);

    localparam logic [VALUE_W-1:0] DEC_BASE = 64'd10;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } text_char_t;

    text_char_t expected_text[$];

    // Decimal text of one operand, most significant character first.
    function automatic void predict_decimal_text(input logic [VALUE_W-1:0] operand,
                                                 input logic func);
        logic [VALUE_W-1:0] mag;
        logic               neg;
        logic [CHAR_W-1:0]  digit_buf[DIGITS];
        int                 nd;
        neg = (func == FUNC_SIGNED) && operand[VALUE_W-1];
        // two's complement magnitude; the most negative value stays 2^63
        mag = neg ? (~operand + 64'd1) : operand;
        nd  = 0;
        do begin
            digit_buf[nd] = CHAR_ZERO + CHAR_W'(mag % DEC_BASE);
            mag = mag / DEC_BASE;
            nd++;
        end while (mag != 0);
        if (neg)
            expected_text.push_back('{CHAR_MINUS, 1'b0});
        for (int k = nd - 1; k >= 0; k--)
            expected_text.push_back('{digit_buf[k], k == 0});
    endfunction

    initial begin
        mismatch_count    = 0;
        chars_outstanding = 0;
    end

    always @(posedge aclk) begin
        text_char_t exp_c;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_text.size() == 0) begin
                    $display("%0t: unexpected character transfer: got %h last %b",
                             $time, m_tdata, m_tlast);
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    exp_c = expected_text.pop_front();
                    if (m_tdata !== exp_c.ch || m_tlast !== exp_c.last) begin
                        $display("%0t: character mismatch: expected %h last %b, got %h last %b",
                                 $time, exp_c.ch, exp_c.last, m_tdata, m_tlast);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_decimal_text(s_tdata, s_tuser);
            chars_outstanding <= expected_text.size();
        end
    end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the binary to decimal ASCII converter: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb;
    import b2d_pkg::*;

    localparam int RANDOM_ITEMS = 400;
    localparam int CYCLE_LIMIT  = 1_000_000;  // far above the slowest legal run
    localparam int HOLD_CYCLES  = 2500;       // long output back-pressure stretch
    localparam int HOLD_AFTER   = 60;         // operands sent before that stretch
    localparam int DRAIN_CYCLES = 200;        // longer than a full load, shift and emit run

    logic               aclk;
    logic               aresetn;
    logic               s_tvalid;
    logic               s_tready;
    logic [VALUE_W-1:0] s_tdata;   // [63:0] value
    logic               s_tuser;   // [0] func: 0 unsigned, 1 signed
    logic               m_tvalid;
    logic               m_tready;
    logic [CHAR_W-1:0]  m_tdata;   // [7:0] character
    logic               m_tlast;

    int mismatch_count;
    int chars_outstanding;
    int operands_sent;
    int burst_left;
    int cycle_count;

    binary_to_decimal_ascii dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    b2d_text_checker chk (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tuser           (s_tuser),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .m_tlast           (m_tlast),
        .mismatch_count    (mismatch_count),
        .chars_outstanding (chars_outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Watchdog: a hung handshake or lost characters end here.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Offer one operand. Bursts of back-to-back transfers alternate with
    // random gaps; inside a burst tvalid stays high from one item to the next.
    task automatic send_operand(input logic [VALUE_W-1:0] value, input logic func);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 8);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= func;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        operands_sent++;
        burst_left--;
    endtask

    // Operand shapes that stress the digit count, the sign and the carries
    // around powers of ten, not just uniformly random 20-digit numbers.
    function automatic logic [VALUE_W-1:0] random_operand();
        logic [VALUE_W-1:0] full;
        logic [VALUE_W-1:0] pow10;
        int                 exp10;
        full = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: return full;
            1: return VALUE_W'($urandom_range(0, 1000));
            2: return 64'd0 - VALUE_W'($urandom_range(1, 1000));  // small negatives
            3: return full >> $urandom_range(0, 63);               // random length
            4: begin
                exp10 = $urandom_range(0, 19);
                pow10 = 64'd1;
                repeat (exp10) pow10 = pow10 * 64'd10;
                return pow10 - 64'd1 + VALUE_W'($urandom_range(0, 2));
            end
            default: return ~(full >> $urandom_range(0, 63));     // sign-extended
        endcase
    endfunction

    // Receiver: stretches of always-ready, random, mostly-ready and mostly
    // stalled. Once, after some traffic, it holds off long enough for the
    // converter to fill and push back on its input while operands are offered.
    initial begin
        int  mode;
        int  span;
        bit  held;
        held = 1'b0;
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (!held && operands_sent >= HOLD_AFTER) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 300);
            repeat (span) begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 3) != 0);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge aclk);
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        s_tvalid      <= 1'b0;
        s_tdata       <= '0;
        s_tuser       <= FUNC_UNSIGNED;
        aresetn       <= 1'b0;
        operands_sent = 0;
        burst_left    = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: zero both ways, single digits, digit-count boundaries,
        // the full unsigned range, -1 and the most negative signed value.
        send_operand(64'd0, FUNC_UNSIGNED);
        send_operand(64'd0, FUNC_SIGNED);
        send_operand(64'd1, FUNC_UNSIGNED);
        send_operand(64'd9, FUNC_SIGNED);
        send_operand(64'd10, FUNC_UNSIGNED);
        send_operand(64'd99, FUNC_SIGNED);
        send_operand(64'd100, FUNC_UNSIGNED);
        send_operand(64'hFFFF_FFFF_FFFF_FFFF, FUNC_UNSIGNED);
        send_operand(64'hFFFF_FFFF_FFFF_FFFF, FUNC_SIGNED);
        send_operand(64'h8000_0000_0000_0000, FUNC_SIGNED);
        send_operand(64'h8000_0000_0000_0000, FUNC_UNSIGNED);
        send_operand(64'h8000_0000_0000_0001, FUNC_SIGNED);
        send_operand(64'h7FFF_FFFF_FFFF_FFFF, FUNC_SIGNED);
        send_operand(64'h7FFF_FFFF_FFFF_FFFF, FUNC_UNSIGNED);
        send_operand(64'd9999999999999999999, FUNC_UNSIGNED);
        send_operand(64'd10000000000000000000, FUNC_UNSIGNED);
        send_operand(64'd12345678901234567890, FUNC_UNSIGNED);
        send_operand(64'hFFFF_FFFF_FFFF_FFF6, FUNC_SIGNED);  // -10
        send_operand(64'h5555_5555_5555_5555, FUNC_SIGNED);
        send_operand(64'hAAAA_AAAA_AAAA_AAAA, FUNC_SIGNED);

        repeat (RANDOM_ITEMS)
            send_operand(random_operand(), 1'($urandom_range(0, 1)));
        s_tvalid <= 1'b0;

        // Let the count of the last transfer settle before it is polled.
        @(posedge aclk);

        // Every operand yields at least one character, so an empty
        // expectation store means the converter has drained.
        while (chars_outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && chars_outstanding == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== binary_to_decimal_ascii.f =====
rtl/core/b2d_pkg.sv
rtl/core/b2d_dabble.sv
rtl/core/b2d_emit.sv
rtl/core/binary_to_decimal_ascii.sv
dv/b2d_text_checker.sv
dv/tb.sv
